// ===== src/mexp_pkg.sv =====
// Package for the modular exponentiation block.
// Holds the default datapath width and the modulus reset value; no dependencies.
`default_nettype none

package mexp_pkg;

    localparam int WORD_BITS_DEFAULT = 64;

    // Modulus after reset, truncated to the datapath width where it is used
    localparam logic [63:0] MOD_RESET = 64'd1000000007;

endpackage : mexp_pkg

`default_nettype wire

// ===== src/modular_exponentiation.sv =====
// Modular exponentiation: base^exponent mod modulus, right-to-left square-and-multiply.
// Bit-serial multipliers first reduce the base, then work through the exponent one bit at a time.
// A new item is not taken while one is busy; the next item is taken at the edge that ends the
// strobe cycle. The receiver cannot stall.
// Synchronous active-low reset idles the block and loads the modulus. Depends on mexp_pkg.
`default_nettype none

module modular_exponentiation #(
    parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // item channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_action,
    input  wire logic [WORD_BITS-1:0] i_base,
    input  wire logic [WORD_BITS-1:0] i_exponent,
    // result
    output logic                      o_done,
    output logic [WORD_BITS-1:0]      o_power_result,
    // modulus write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [WORD_BITS-1:0] i_cfg_data
);

    import mexp_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,   // base mod modulus, computed as base * 1 mod modulus
        S_LOOP      // one square and one multiply per exponent bit, side by side
    } t_state;

    t_state                r_state;
    logic [WORD_BITS-1:0]  r_mod;
    logic                  r_mod_zero;     // no reduction: products wrap
    logic                  r_mod_one;      // 1 mod modulus is 0
    logic [WORD_BITS-1:0]  r_exp;          // effective exponent, shifted right per step
    logic [WORD_BITS-1:0]  r_res;          // running result, starts at 1
    logic [WORD_BITS-1:0]  r_base;         // reduced base, squared per step
    logic [WORD_BITS-1:0]  r_sh_r;         // multiplier bits of the result product
    logic [WORD_BITS-1:0]  r_sh_b;         // multiplier bits of the square / base reduction
    logic [WORD_BITS-1:0]  r_acc_r;
    logic [WORD_BITS-1:0]  r_acc_b;
    logic [CNT_W-1:0]      r_bit_cnt;
    logic [CNT_W-1:0]      r_step_cnt;

    logic [WORD_BITS-1:0]  n_acc_r;
    logic [WORD_BITS-1:0]  n_acc_b;
    logic [WORD_BITS-1:0]  n_res;
    logic [WORD_BITS-1:0]  w_addend_b;
    logic [WORD_BITS-1:0]  w_one;

    // One interleaved step: (2*acc + bit*add) mod m, with acc, add below m.
    // The sum stays below 3m, so one of three candidates is the answer.
    function automatic logic [WORD_BITS-1:0] f_mod_step(
        input logic [WORD_BITS-1:0] acc,
        input logic                 mbit,
        input logic [WORD_BITS-1:0] add,
        input logic [WORD_BITS-1:0] m,
        input logic                 m_zero
    );
        logic [WORD_BITS+1:0] t;
        logic [WORD_BITS+1:0] t1;
        logic [WORD_BITS+1:0] t2;
        logic [WORD_BITS+1:0] m1;
        logic [WORD_BITS+1:0] m2;
        t  = {1'b0, acc, 1'b0} + (mbit ? {2'b00, add} : '0);
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        t1 = t - m1;
        t2 = t - m2;
        if (m_zero) begin
            return t[WORD_BITS-1:0];
        end else if (t >= m2) begin
            return t2[WORD_BITS-1:0];
        end else if (t >= m1) begin
            return t1[WORD_BITS-1:0];
        end
        return t[WORD_BITS-1:0];
    endfunction

    assign w_one      = r_mod_one ? '0 : WORD_BITS'(1);
    assign w_addend_b = (r_state == S_REDUCE) ? w_one : r_base;

    assign n_acc_r = f_mod_step(r_acc_r, r_sh_r[WORD_BITS-1], r_base, r_mod, r_mod_zero);
    assign n_acc_b = f_mod_step(r_acc_b, r_sh_b[WORD_BITS-1], w_addend_b, r_mod, r_mod_zero);

    // Take the product into the result only where the exponent bit is set
    assign n_res = r_exp[0] ? n_acc_r : r_res;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            o_done     <= 1'b0;
            r_mod      <= MOD_RESET[WORD_BITS-1:0];
            r_mod_zero <= 1'b0;
            r_mod_one  <= 1'b0;
            r_bit_cnt  <= '0;
            r_step_cnt <= '0;
        end else begin
            o_done <= 1'b0;

            // modulus writes must arrive only while idle; the block itself does not enforce this
            if (i_cfg_valid) begin
                r_mod      <= i_cfg_data;
                r_mod_zero <= (i_cfg_data == '0);
                r_mod_one  <= (i_cfg_data == WORD_BITS'(1));
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        // inverse action: Fermat exponent, wrapping for tiny moduli
                        r_exp     <= i_action ? (r_mod - WORD_BITS'(2)) : i_exponent;
                        r_res     <= WORD_BITS'(1);
                        r_sh_b    <= i_base;
                        r_acc_b   <= '0;
                        r_bit_cnt <= '0;
                        r_state   <= S_REDUCE;
                    end
                end

                S_REDUCE: begin
                    r_acc_b   <= n_acc_b;
                    r_sh_b    <= r_sh_b << 1;
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                    if (r_bit_cnt == LAST) begin
                        // reduced base is ready: load both multipliers for step 0
                        r_base     <= n_acc_b;
                        r_sh_b     <= n_acc_b;
                        r_sh_r     <= r_res;
                        r_acc_b    <= '0;
                        r_acc_r    <= '0;
                        r_bit_cnt  <= '0;
                        r_step_cnt <= '0;
                        r_state    <= S_LOOP;
                    end
                end

                S_LOOP: begin
                    r_acc_r   <= n_acc_r;
                    r_acc_b   <= n_acc_b;
                    r_sh_r    <= r_sh_r << 1;
                    r_sh_b    <= r_sh_b << 1;
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                    if (r_bit_cnt == LAST) begin
                        // end of one exponent bit: commit product and square
                        r_res      <= n_res;
                        r_base     <= n_acc_b;
                        r_sh_r     <= n_res;
                        r_sh_b     <= n_acc_b;
                        r_acc_r    <= '0;
                        r_acc_b    <= '0;
                        r_exp      <= r_exp >> 1;
                        r_bit_cnt  <= '0;
                        r_step_cnt <= r_step_cnt + 1'b1;
                        if (r_step_cnt == LAST) begin
                            o_power_result <= n_res;
                            o_done         <= 1'b1;
                            r_state        <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    // the strobe comes only once the block has gone idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // an accepted item always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start");

    // one strobe per item, never two in a row
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // the addend of both multipliers stays reduced
    a_base_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP && !r_mod_zero) |-> (r_base < r_mod))
        else $error("base not reduced below modulus");

    // the accumulators stay reduced during a multiplication
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP && !r_mod_zero) |-> (r_acc_r < r_mod && r_acc_b < r_mod))
        else $error("accumulator not reduced below modulus");

endmodule : modular_exponentiation

`default_nettype wire
